// ===== sv/obq_pkg.sv =====
// Package: widths, constants and shared types for the occluder box qualifier.
package obq_pkg;
  localparam int ModelWidth = 20;
  localparam int WorldWidth = 21;
  localparam int CfgWidth   = 63;
  localparam int CfgIdxWidth = 3;
  localparam int CoefWidth  = 16;
  localparam int PackWidth  = 21;
  // sum of three 16x20 products
  localparam int SumWidth   = CoefWidth + ModelWidth + 2;
  localparam int FineWidth  = SumWidth - 10 + 1;
  localparam int ScaledWidth = FineWidth + 17;
  localparam int WholeWidth = ScaledWidth - 16 + 1;
  localparam int QueueDepth = 4;
  localparam int QueuePtrWidth = 2;

  typedef enum logic [1:0] {
    VerdictAccept = 2'd0,
    VerdictThin   = 2'd1,
    VerdictInside = 2'd2
  } verdict_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegRotX   = 3'd0,
    RegRotY   = 3'd1,
    RegRotZ   = 3'd2,
    RegScale  = 3'd3,
    RegOffset = 3'd4,
    RegEye    = 3'd5,
    RegMinDim = 3'd6,
    RegMargin = 3'd7
  } reg_idx_e;

  localparam logic signed [WorldWidth-1:0] WorldMax = {1'b0, {(WorldWidth-1){1'b1}}};
  localparam logic signed [WorldWidth-1:0] WorldMin = {1'b1, {(WorldWidth-1){1'b0}}};

  typedef struct packed {
    logic signed [WorldWidth-1:0] x;
    logic signed [WorldWidth-1:0] y;
    logic signed [WorldWidth-1:0] z;
    logic                         last;
  } world_vtx_t;

  typedef struct packed {
    logic [2:0][47:0] rot;
    logic [15:0]      scale;
    logic [62:0]      offset;
    logic [62:0]      eye;
    logic [15:0]      min_dim;
    logic [15:0]      margin;
  } cfg_t;
endpackage

// ===== sv/obq_if.sv =====
// Valid/ready stream interfaces for vertices and results.
interface obq_vtx_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [obq_pkg::ModelWidth-1:0] model_x;
  logic signed [obq_pkg::ModelWidth-1:0] model_y;
  logic signed [obq_pkg::ModelWidth-1:0] model_z;
  logic                                  final_vertex;
  modport source (output valid, model_x, model_y, model_z, final_vertex, input ready);
  modport sink (input valid, model_x, model_y, model_z, final_vertex, output ready);
endinterface

interface obq_res_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            verdict;
  logic signed [obq_pkg::WorldWidth-1:0] box_low_x;
  logic signed [obq_pkg::WorldWidth-1:0] box_low_y;
  logic signed [obq_pkg::WorldWidth-1:0] box_low_z;
  logic signed [obq_pkg::WorldWidth-1:0] box_high_x;
  logic signed [obq_pkg::WorldWidth-1:0] box_high_y;
  logic signed [obq_pkg::WorldWidth-1:0] box_high_z;
  modport source (output valid, verdict, box_low_x, box_low_y, box_low_z,
                  box_high_x, box_high_y, box_high_z, input ready);
  modport sink (input valid, verdict, box_low_x, box_low_y, box_low_z,
                box_high_x, box_high_y, box_high_z, output ready);
endinterface

// ===== sv/obq_xform.sv =====
// Front end: pipelined vertex transform into saturated world coordinates.
module obq_xform (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  obq_pkg::cfg_t       cfg_i,
  obq_vtx_if.sink             vtx,
  input  logic                space_i,
  output logic                out_valid_o,
  output obq_pkg::world_vtx_t out_vtx_o
);
  localparam int SW = obq_pkg::SumWidth;
  localparam int FW = obq_pkg::FineWidth;
  localparam int CW = obq_pkg::ScaledWidth;
  localparam int HW = obq_pkg::WholeWidth;
  localparam int WW = obq_pkg::WorldWidth;

  // s1: products, s2: sums+round, s3: scale, s4: round+offset+saturate
  logic [3:0] v_q;
  logic [3:0] last_q;
  logic signed [SW-1:0] prod_q [3][3];
  logic signed [FW-1:0] fine_q [3];
  logic signed [CW-1:0] scaled_q [3];
  logic signed [WW-1:0] world_q [3];

  logic accept;
  // pipeline holds at most four items; the front only takes one if room is promised
  assign vtx.ready = space_i;
  assign accept = vtx.valid && vtx.ready;

  logic signed [obq_pkg::ModelWidth-1:0] m [3];
  assign m[0] = vtx.model_x;
  assign m[1] = vtx.model_y;
  assign m[2] = vtx.model_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      last_q <= '0;
    end else begin
      v_q <= {v_q[2:0], accept};
      last_q <= {last_q[2:0], vtx.final_vertex};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[a][i] <= SW'($signed(cfg_i.rot[a][16*i +: 16]) * m[i]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      logic signed [SW-1:0] s;
      s = prod_q[a][0] + prod_q[a][1] + prod_q[a][2] + SW'(512);
      fine_q[a] <= FW'(s >>> 10);
    end
    for (int a = 0; a < 3; a++) begin
      scaled_q[a] <= fine_q[a] * $signed({1'b0, cfg_i.scale});
    end
    for (int a = 0; a < 3; a++) begin
      logic signed [HW-1:0] wsum;
      wsum = HW'((scaled_q[a] + CW'(32768)) >>> 16)
           + HW'($signed(cfg_i.offset[obq_pkg::PackWidth*a +: obq_pkg::PackWidth]));
      if (wsum > HW'(obq_pkg::WorldMax)) world_q[a] <= obq_pkg::WorldMax;
      else if (wsum < HW'(obq_pkg::WorldMin)) world_q[a] <= obq_pkg::WorldMin;
      else world_q[a] <= WW'(wsum);
    end
  end

  assign out_valid_o    = v_q[3];
  assign out_vtx_o.x    = world_q[0];
  assign out_vtx_o.y    = world_q[1];
  assign out_vtx_o.z    = world_q[2];
  assign out_vtx_o.last = last_q[3];
endmodule

// ===== sv/obq_queue.sv =====
// Short FIFO between transform front end and box back end.
module obq_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  obq_pkg::world_vtx_t wdata_i,
  input  logic                rd_i,
  output logic                empty_o,
  output obq_pkg::world_vtx_t rdata_o,
  output logic [obq_pkg::QueuePtrWidth:0] count_o
);
  localparam int PW = obq_pkg::QueuePtrWidth;
  obq_pkg::world_vtx_t mem_q [obq_pkg::QueueDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(wr_i) - (PW+1)'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
endmodule

// ===== sv/obq_box.sv =====
// Back end: running min/max box, mesh tests and shrunken box result (zeroed for thin or inside meshes).
module obq_box (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  obq_pkg::cfg_t       cfg_i,
  input  logic                empty_i,
  input  obq_pkg::world_vtx_t vtx_i,
  output logic                pop_o,
  obq_res_if.source           res
);
  localparam int WW = obq_pkg::WorldWidth;
  localparam int EW = WW + 2;

  typedef enum logic [1:0] {StAcc, StTest, StShrink, StOut} state_e;
  state_e state_q;

  logic signed [WW-1:0] min_q [3];
  logic signed [WW-1:0] max_q [3];
  logic signed [WW-1:0] lo_q [3];
  logic signed [WW-1:0] hi_q [3];
  logic signed [EW-1:0] ext_q [3];
  logic signed [WW-1:0] w [3];
  logic [1:0] verdict_q;
  logic [1:0] thin_cnt;
  logic eye_in;

  assign w[0] = vtx_i.x;
  assign w[1] = vtx_i.y;
  assign w[2] = vtx_i.z;
  assign pop_o = (state_q == StAcc) && !empty_i;

  always_comb begin
    thin_cnt = '0;
    eye_in = 1'b1;
    for (int a = 0; a < 3; a++) begin
      logic signed [EW-1:0] e;
      e = EW'($signed(cfg_i.eye[obq_pkg::PackWidth*a +: obq_pkg::PackWidth]));
      if (ext_q[a] < $signed({{(EW-16){1'b0}}, cfg_i.min_dim})) thin_cnt = thin_cnt + 2'd1;
      if (e < EW'(lo_q[a]) - $signed({{(EW-16){1'b0}}, cfg_i.margin}) ||
          e > EW'(hi_q[a]) + $signed({{(EW-16){1'b0}}, cfg_i.margin})) eye_in = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAcc;
      verdict_q <= obq_pkg::VerdictAccept;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= obq_pkg::WorldMax;
        max_q[a] <= obq_pkg::WorldMin;
        lo_q[a] <= '0;
        hi_q[a] <= '0;
        ext_q[a] <= '0;
      end
    end else begin
      case (state_q)
        StAcc: begin
          if (!empty_i) begin
            for (int a = 0; a < 3; a++) begin
              logic signed [WW-1:0] mn, mx;
              mn = (w[a] < min_q[a]) ? w[a] : min_q[a];
              mx = (w[a] > max_q[a]) ? w[a] : max_q[a];
              if (vtx_i.last) begin
                lo_q[a] <= mn;
                hi_q[a] <= mx;
                ext_q[a] <= EW'(mx) - EW'(mn);
                min_q[a] <= obq_pkg::WorldMax;
                max_q[a] <= obq_pkg::WorldMin;
              end else begin
                min_q[a] <= mn;
                max_q[a] <= mx;
              end
            end
            if (vtx_i.last) state_q <= StTest;
          end
        end
        StTest: begin
          if (thin_cnt >= 2'd2) begin
            verdict_q <= obq_pkg::VerdictThin;
            lo_q <= '{default: '0};
            hi_q <= '{default: '0};
            state_q <= StOut;
          end else if (eye_in) begin
            verdict_q <= obq_pkg::VerdictInside;
            lo_q <= '{default: '0};
            hi_q <= '{default: '0};
            state_q <= StOut;
          end else begin
            verdict_q <= obq_pkg::VerdictAccept;
            state_q <= StShrink;
          end
        end
        StShrink: begin
          // t = floor((d+5)/10) via reciprocal: (x*52429)>>19 exact for x < 2^18, then a one-step fix either way
          for (int a = 0; a < 3; a++) begin
            logic [EW+16:0] p;
            logic [EW-1:0] t;
            logic [EW-1:0] x;
            x = ext_q[a] + EW'(5);
            p = (EW+17)'(x) * (EW+17)'(17'd52429);
            t = EW'(p >> 19);
            if (EW'(t * 10) > x) t = t - 1'b1;
            else if (EW'(t * 10 + 10) <= x) t = t + 1'b1;
            lo_q[a] <= WW'(EW'(lo_q[a]) + t);
            hi_q[a] <= WW'(EW'(hi_q[a]) - t);
          end
          state_q <= StOut;
        end
        StOut: begin
          if (res.ready) state_q <= StAcc;
        end
        default: state_q <= StAcc;
      endcase
    end
  end

  assign res.valid      = (state_q == StOut);
  assign res.verdict    = verdict_q;
  assign res.box_low_x  = lo_q[0];
  assign res.box_low_y  = lo_q[1];
  assign res.box_low_z  = lo_q[2];
  assign res.box_high_x = hi_q[0];
  assign res.box_high_y = hi_q[1];
  assign res.box_high_z = hi_q[2];
endmodule

// ===== sv/occluder_box_qualifier.sv =====
// Top level: config registers, transform front end, queue and box back end.
// Path: a final vertex passes the 4 transform stages, 1 queue write, then fold, test and shrink in the back end;
// a rejected mesh skips shrink.
// Intake: credit for the 4-entry queue covers the transform pipe, so up to four vertices may be in the pipe and
// queue at once; a final vertex holds the back end for test, shrink unless rejected, and the wait for the result.
// Reset: asynchronous, active low; registers take their defaults and the box is emptied.
module occluder_box_qualifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [obq_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [obq_pkg::CfgWidth-1:0]      cfg_data_i,
  obq_vtx_if.sink                           vtx,
  obq_res_if.source                         res
);
  obq_pkg::cfg_t cfg_q;
  logic xf_valid, q_empty, pop, space;
  obq_pkg::world_vtx_t xf_vtx, q_vtx;
  logic [obq_pkg::QueuePtrWidth:0] q_count;
  logic [2:0] inflight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot[0]  <= 48'd16384;
      cfg_q.rot[1]  <= 48'd16384 << 16;
      cfg_q.rot[2]  <= 48'd16384 << 32;
      cfg_q.scale   <= 16'd256;
      cfg_q.offset  <= '0;
      cfg_q.eye     <= '0;
      cfg_q.min_dim <= 16'd128;
      cfg_q.margin  <= 16'd64;
    end else if (cfg_we_i) begin
      case (obq_pkg::reg_idx_e'(cfg_idx_i))
        obq_pkg::RegRotX:   cfg_q.rot[0]  <= cfg_data_i[47:0];
        obq_pkg::RegRotY:   cfg_q.rot[1]  <= cfg_data_i[47:0];
        obq_pkg::RegRotZ:   cfg_q.rot[2]  <= cfg_data_i[47:0];
        obq_pkg::RegScale:  cfg_q.scale   <= cfg_data_i[15:0];
        obq_pkg::RegOffset: cfg_q.offset  <= cfg_data_i;
        obq_pkg::RegEye:    cfg_q.eye     <= cfg_data_i;
        obq_pkg::RegMinDim: cfg_q.min_dim <= cfg_data_i[15:0];
        obq_pkg::RegMargin: cfg_q.margin  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // requests in the transform pipe plus queued entries must fit the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= '0;
    else inflight_q <= inflight_q + 3'(vtx.valid && vtx.ready) - 3'(xf_valid);
  end
  assign space = ({1'b0, q_count} + inflight_q) < 4'(obq_pkg::QueueDepth);

  obq_xform u_xform (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .vtx, .space_i(space),
    .out_valid_o(xf_valid), .out_vtx_o(xf_vtx)
  );

  obq_queue u_queue (
    .clk_i, .rst_ni, .wr_i(xf_valid), .wdata_i(xf_vtx), .rd_i(pop),
    .empty_o(q_empty), .rdata_o(q_vtx), .count_o(q_count)
  );

  obq_box u_box (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(q_empty), .vtx_i(q_vtx),
    .pop_o(pop), .res
  );
endmodule

// ===== dv/occluder_box_qualifier_test.sv =====
// Testbench for the occluder box qualifier: directed cases, then random meshes against a predictor.
module occluder_box_qualifier_test;

  typedef struct packed {
    logic [1:0]                            verdict;
    logic signed [obq_pkg::WorldWidth-1:0] lx;
    logic signed [obq_pkg::WorldWidth-1:0] ly;
    logic signed [obq_pkg::WorldWidth-1:0] lz;
    logic signed [obq_pkg::WorldWidth-1:0] hx;
    logic signed [obq_pkg::WorldWidth-1:0] hy;
    logic signed [obq_pkg::WorldWidth-1:0] hz;
  } box_res_t;

  typedef struct {
    logic signed [obq_pkg::ModelWidth-1:0] x;
    logic signed [obq_pkg::ModelWidth-1:0] y;
    logic signed [obq_pkg::ModelWidth-1:0] z;
    logic                                  last;
    bit                                    typed;
    obq_pkg::verdict_e                     verdict;
  } vtx_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [obq_pkg::CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [obq_pkg::CfgWidth-1:0] cfg_data_i = '0;

  obq_vtx_if vtx ();
  obq_res_if res ();

  occluder_box_qualifier DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .vtx(vtx.sink), .res(res.source)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [47:0] rot_m [3];
  logic [15:0] scale_m, min_dim_m, margin_m;
  logic [62:0] offset_m, eye_m;
  longint box_min [3];
  longint box_max [3];

  box_res_t          expected_boxes [$];
  bit                expected_typed [$];
  obq_pkg::verdict_e typed_verdict [$];
  int mismatches = 0;
  int send_idle = 33, recv_idle = 71;

  function automatic longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint field21(logic [62:0] r, int k);
    logic signed [20:0] f;
    f = r[k*21 +: 21];
    return longint'(f);
  endfunction

  function automatic void empty_box();
    for (int a = 0; a < 3; a++) begin
      box_min[a] = longint'(obq_pkg::WorldMax);
      box_max[a] = longint'(obq_pkg::WorldMin);
    end
  endfunction

  function automatic longint world_coord(int a, longint m [3]);
    longint acc, w;
    logic signed [15:0] c;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      c = rot_m[a][16*i +: 16];
      acc += longint'(c) * m[i];
    end
    w = floor_div(floor_div(acc + 512, 10) * longint'(scale_m) + 32768, 16) + field21(offset_m, a);
    if (w > longint'(obq_pkg::WorldMax)) w = longint'(obq_pkg::WorldMax);
    if (w < longint'(obq_pkg::WorldMin)) w = longint'(obq_pkg::WorldMin);
    return w;
  endfunction

  // folds one vertex into the box; returns 1 with the verdict on a last vertex
  function automatic bit fold_vertex(logic signed [obq_pkg::ModelWidth-1:0] x, y, z,
                                     logic last, output box_res_t r);
    longint m [3];
    longint w, lo [3], hi [3], e, d, t;
    int thin;
    bit eye_in;
    m[0] = x; m[1] = y; m[2] = z;
    r = '0;
    for (int a = 0; a < 3; a++) begin
      w = world_coord(a, m);
      if (w < box_min[a]) box_min[a] = w;
      if (w > box_max[a]) box_max[a] = w;
    end
    if (!last) return 1'b0;
    lo = box_min; hi = box_max;
    empty_box();
    thin = 0; eye_in = 1'b1;
    for (int a = 0; a < 3; a++) begin
      e = field21(eye_m, a);
      if (hi[a] - lo[a] < longint'(min_dim_m)) thin++;
      if (!(e >= lo[a] - longint'(margin_m) && e <= hi[a] + longint'(margin_m))) eye_in = 1'b0;
    end
    if (thin >= 2) r.verdict = obq_pkg::VerdictThin;
    else if (eye_in) r.verdict = obq_pkg::VerdictInside;
    else begin
      r.verdict = obq_pkg::VerdictAccept;
      d = hi[0] - lo[0]; t = (d + 5) / 10; r.lx = lo[0] + t; r.hx = hi[0] - t;
      d = hi[1] - lo[1]; t = (d + 5) / 10; r.ly = lo[1] + t; r.hy = hi[1] - t;
      d = hi[2] - lo[2]; t = (d + 5) / 10; r.lz = lo[2] + t; r.hz = hi[2] - t;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(obq_pkg::reg_idx_e idx, logic [62:0] value);
    vtx.valid <= 1'b0;
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      obq_pkg::RegRotX:   rot_m[0] = value[47:0];
      obq_pkg::RegRotY:   rot_m[1] = value[47:0];
      obq_pkg::RegRotZ:   rot_m[2] = value[47:0];
      obq_pkg::RegScale:  scale_m = value[15:0];
      obq_pkg::RegOffset: offset_m = value;
      obq_pkg::RegEye:    eye_m = value;
      obq_pkg::RegMinDim: min_dim_m = value[15:0];
      obq_pkg::RegMargin: margin_m = value[15:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    vtx.valid <= 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // drives one vertex request; vtx.valid stays high after it until the caller idles
  task automatic send_vertex(logic signed [obq_pkg::ModelWidth-1:0] x, y, z, logic last,
                             bit typed, obq_pkg::verdict_e tv);
    box_res_t r;
    while ($urandom_range(99) < send_idle) begin
      vtx.valid <= 1'b0;
      @(negedge clk_i);
    end
    vtx.valid <= 1'b1;
    vtx.model_x <= x; vtx.model_y <= y; vtx.model_z <= z; vtx.final_vertex <= last;
    do @(posedge clk_i); while (!vtx.ready);
    if (fold_vertex(x, y, z, last, r)) begin
      expected_boxes.push_back(r);
      expected_typed.push_back(typed);
      typed_verdict.push_back(tv);
    end
    @(negedge clk_i);
  endtask

  function automatic logic signed [obq_pkg::ModelWidth-1:0] rand_model(bit wide);
    if (wide) return obq_pkg::ModelWidth'($urandom);
    return obq_pkg::ModelWidth'($signed($urandom_range(8000)) - 4000);
  endfunction

  task automatic random_mesh(bit wide);
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++)
      send_vertex(rand_model(wide), rand_model(wide), rand_model(wide), i == n - 1,
                  1'b0, obq_pkg::VerdictAccept);
  endtask

  task automatic random_config(bit extreme);
    for (int a = 0; a < 3; a++) begin
      if (extreme) write_reg(obq_pkg::reg_idx_e'(a), 63'({$urandom, $urandom}));
      else write_reg(obq_pkg::reg_idx_e'(a),
                     63'(rot_m[a] ^ (48'(16'($urandom_range(800))) << (16 * a))));
    end
    write_reg(obq_pkg::RegScale,
              extreme ? 63'($urandom_range(65535)) : 63'($urandom_range(600, 40)));
    write_reg(obq_pkg::RegOffset, extreme ? 63'({$urandom, $urandom}) :
      {21'($signed($urandom_range(2000)) - 1000), 21'($signed($urandom_range(2000)) - 1000),
       21'($signed($urandom_range(2000)) - 1000)});
    write_reg(obq_pkg::RegEye, {21'($signed($urandom_range(800)) - 400),
       21'($signed($urandom_range(800)) - 400), 21'($signed($urandom_range(800)) - 400)});
    write_reg(obq_pkg::RegMinDim,
              extreme ? 63'($urandom_range(65535)) : 63'($urandom_range(200)));
    write_reg(obq_pkg::RegMargin,
              extreme ? 63'($urandom_range(65535)) : 63'($urandom_range(100)));
  endtask

  // result checker
  always @(posedge clk_i) begin
    box_res_t got, want;
    bit typed;
    obq_pkg::verdict_e tv;
    if (rst_ni && res.valid && res.ready) begin
      got = {res.verdict, res.box_low_x, res.box_low_y, res.box_low_z,
             res.box_high_x, res.box_high_y, res.box_high_z};
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_boxes.pop_front();
        typed = expected_typed.pop_front();
        tv = typed_verdict.pop_front();
        if (got !== want || (typed && got.verdict !== tv)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("box mismatch: expected %h (verdict %0d) got %h", want, want.verdict, got);
        end
      end
    end
  end

  always @(negedge clk_i) res.ready <= ($urandom_range(99) >= recv_idle);

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  vtx_row_t rows [$];

  initial begin
    vtx.valid = 1'b0; vtx.model_x = '0; vtx.model_y = '0; vtx.model_z = '0;
    vtx.final_vertex = 1'b0; res.ready = 1'b0;
    rot_m[0] = 48'd16384; rot_m[1] = 48'd16384 << 16; rot_m[2] = 48'd16384 << 32;
    scale_m = 16'd256; offset_m = '0; eye_m = '0; min_dim_m = 16'd128; margin_m = 16'd64;
    empty_box();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: single points are thin; eye at origin inside; extremes; broad accept
    rows = '{
      '{20'sd0, 20'sd0, 20'sd0, 1'b1, 1'b1, obq_pkg::VerdictThin},
      '{20'sd524287, 20'sd524287, 20'sd524287, 1'b1, 1'b1, obq_pkg::VerdictThin},
      '{-20'sd524288, -20'sd524288, -20'sd524288, 1'b0, 1'b0, obq_pkg::VerdictAccept},
      '{20'sd524287, 20'sd524287, 20'sd524287, 1'b1, 1'b0, obq_pkg::VerdictAccept},
      '{-20'sd3200, -20'sd3200, -20'sd3200, 1'b0, 1'b0, obq_pkg::VerdictAccept},
      '{20'sd3200, 20'sd3200, 20'sd3200, 1'b1, 1'b1, obq_pkg::VerdictInside},
      '{20'sd16000, 20'sd16000, 20'sd16000, 1'b0, 1'b0, obq_pkg::VerdictAccept},
      '{20'sd32000, 20'sd32000, 20'sd32000, 1'b1, 1'b1, obq_pkg::VerdictAccept},
      '{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b0, obq_pkg::VerdictAccept},
      '{20'sd8000, 20'sd0, 20'sd0, 1'b1, 1'b1, obq_pkg::VerdictThin},
      '{-20'sd1, 20'sd1, -20'sd8, 1'b0, 1'b0, obq_pkg::VerdictAccept},
      '{20'sd8000, 20'sd8000, 20'sd0, 1'b1, 1'b0, obq_pkg::VerdictAccept}
    };
    foreach (rows[i])
      send_vertex(rows[i].x, rows[i].y, rows[i].z, rows[i].last, rows[i].typed, rows[i].verdict);
    drain_results();
    // saturation with extreme scale, offset and coefficients
    write_reg(obq_pkg::RegScale, 63'hFFFF);
    write_reg(obq_pkg::RegOffset, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
    write_reg(obq_pkg::RegRotX, 63'(48'h8000_8000_8000));
    send_vertex(20'sd524287, -20'sd524288, 20'sd524287, 1'b0, 1'b0, obq_pkg::VerdictAccept);
    send_vertex(-20'sd524288, 20'sd524287, -20'sd524288, 1'b1, 1'b0, obq_pkg::VerdictAccept);
    drain_results();
    write_reg(obq_pkg::RegMinDim, '0); write_reg(obq_pkg::RegMargin, 63'hFFFF);
    write_reg(obq_pkg::RegScale, '0);
    write_reg(obq_pkg::RegEye, '1);
    send_vertex(20'sd5, 20'sd5, 20'sd5, 1'b1, 1'b0, obq_pkg::VerdictAccept);
    drain_results();

    for (int phase = 0; phase < 9; phase++) begin
      send_idle = (phase < 3) ? 33 : (phase < 6) ? 71 : 0;
      recv_idle = (phase < 3) ? 71 : (phase < 6) ? 33 : 0;
      random_config(phase % 3 == 2);
      for (int m = 0; m < 42; m++) begin
        random_mesh($urandom_range(9) == 0);
        // hold off until every pending box has come out
        if (m == 20) begin
          vtx.valid <= 1'b0;
          while (expected_boxes.size() != 0) @(negedge clk_i);
        end
      end
      drain_results();
    end

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/obq_pkg.sv
sv/obq_if.sv
sv/obq_xform.sv
sv/obq_queue.sv
sv/obq_box.sv
sv/occluder_box_qualifier.sv
dv/occluder_box_qualifier_test.sv
